// ===== design/vagp_pkg.sv =====
package vagp_pkg;

    localparam int FRAME_SAMPLES = 1024;
    localparam int PREROLL_DEPTH = 8;
    localparam int BACKLOG_DEPTH = 8;

    localparam int PRE_IW = (PREROLL_DEPTH > 8) ? 4 : 3;
    localparam int BKL_IW = (BACKLOG_DEPTH > 8) ? 4 : 3;
    localparam int CNT_W = 4;
    localparam int SUM_W = 26;
    localparam int CMP_W = 34;

    localparam logic [15:0] ALWAYS_VOICE = 16'hFFFF;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [15:0] RST_VOICE_THRESHOLD = 16'd250;
    localparam logic [7:0] RST_DEBOUNCE_FRAMES = 8'd3;
    localparam logic [31:0] RST_SILENCE_HOLD_MS = 32'd10000;
    localparam logic [31:0] RST_FORCE_HOLD_MS = 32'd50000;

    localparam logic [1:0] REG_VOICE_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE_FRAMES = 2'd1;
    localparam logic [1:0] REG_SILENCE_HOLD_MS = 2'd2;
    localparam logic [1:0] REG_FORCE_HOLD_MS = 2'd3;

    localparam logic [2:0] ACT_STORE_PREROLL = 3'd0;
    localparam logic [2:0] ACT_FORWARD_LIVE = 3'd1;
    localparam logic [2:0] ACT_REPLAY_PREROLL = 3'd2;
    localparam logic [2:0] ACT_FLUSH_BACKLOG = 3'd3;
    localparam logic [2:0] ACT_DROP_LIVE = 3'd4;

    typedef struct packed {
        logic signed [15:0] sample;
        logic frame_last;
        logic [31:0] now_ms;
        logic wake_event;
        logic force_press;
    } vagp_in_t;

    typedef struct packed {
        logic [2:0] frame_action;
        logic [2:0] write_slot;
        logic [2:0] read_slot;
        logic recording;
        logic sleeping;
        logic started;
        logic stopped;
        logic voiced;
    } vagp_out_t;

endpackage

// ===== design/voice_activity_gate_preroll.sv =====
// Amplitude voice-activity gate with debounce, silence hold and pre-roll replay. The block
// takes one PCM sample per request and can accept a request in every clock cycle unless a
// stalled result holds it. Sample magnitudes are summed over each frame; the sample marked
// frame_last closes the frame, and its frame decision appears in the output register in the
// cycle after that request is accepted. The output register is the only buffer: a new
// sample is accepted whenever that register is empty or its result is taken in the same
// cycle, so a stalled result holds the input side for as long as it waits. Samples that are
// not the last of a frame give no result. The user must write configuration registers only
// through the plain write port while no frame is in flight; the block does not enforce it.
module voice_activity_gate_preroll (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  vagp_pkg::vagp_in_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output vagp_pkg::vagp_out_t out_data
);
    import vagp_pkg::*;

    logic [15:0] voice_threshold_reg;
    logic [7:0] debounce_frames_reg;
    logic [31:0] silence_hold_ms_reg;
    logic [31:0] force_hold_ms_reg;

    logic [SUM_W-1:0] amplitude_sum_reg, amplitude_sum_next;
    logic is_recording_reg, is_recording_next;
    logic is_sleeping_reg, is_sleeping_next;
    logic [7:0] voice_streak_reg, voice_streak_next;
    logic [31:0] last_voice_time_reg, last_voice_time_next;
    logic [31:0] force_deadline_reg, force_deadline_next;
    logic [PRE_IW-1:0] preroll_write_index_reg, preroll_write_index_next;
    logic [CNT_W-1:0] preroll_count_reg, preroll_count_next;
    logic [PRE_IW-1:0] replay_index_reg, replay_index_next;
    logic [CNT_W-1:0] replay_pending_reg, replay_pending_next;
    logic [BKL_IW-1:0] backlog_read_index_reg, backlog_read_index_next;
    logic [BKL_IW-1:0] backlog_write_index_reg, backlog_write_index_next;
    logic [CNT_W-1:0] backlog_count_reg, backlog_count_next;

    logic out_valid_reg, out_valid_next;
    vagp_out_t out_data_reg, out_data_next;

    logic accept;
    logic [16:0] mag;
    logic [SUM_W:0] acc_sum;
    logic [SUM_W-1:0] acc_sat;
    logic [CMP_W-1:0] threshold_target;
    logic [32:0] deadline_sum;
    logic force_active;
    logic voiced;
    logic [31:0] silence_span;
    logic [CNT_W-1:0] replay_n;
    logic [CNT_W-1:0] replay_mod;
    logic [CNT_W:0] replay_base_raw;
    logic [PRE_IW-1:0] replay_base;
    logic [2:0] action;
    logic [PRE_IW-1:0] wslot_pre;
    logic [BKL_IW-1:0] wslot_bkl;
    logic [PRE_IW-1:0] rslot_pre;
    logic [BKL_IW-1:0] rslot_bkl;
    logic use_bkl_wslot;
    logic use_bkl_rslot;
    logic started;
    logic stopped;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    assign mag = in_data.sample[15] ? (17'h10000 - {1'b0, in_data.sample}) : {1'b0, in_data.sample};
    assign acc_sum = {1'b0, amplitude_sum_reg} + {{(SUM_W-16){1'b0}}, mag};
    assign acc_sat = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
    assign threshold_target = {{(CMP_W-16){1'b0}}, voice_threshold_reg} * CMP_W'(FRAME_SAMPLES);
    assign deadline_sum = {1'b0, in_data.now_ms} + {1'b0, force_hold_ms_reg};

    assign replay_n = (preroll_count_reg > CNT_W'(BACKLOG_DEPTH)) ? CNT_W'(BACKLOG_DEPTH)
                                                                  : preroll_count_reg;
    assign replay_mod = (replay_n < CNT_W'(PREROLL_DEPTH)) ? replay_n
                                                           : replay_n - CNT_W'(PREROLL_DEPTH);
    assign replay_base_raw = (CNT_W+1)'(preroll_write_index_reg) + (CNT_W+1)'(PREROLL_DEPTH)
                             - (CNT_W+1)'(replay_mod);
    assign replay_base = (replay_base_raw >= (CNT_W+1)'(PREROLL_DEPTH))
                         ? PRE_IW'(replay_base_raw - (CNT_W+1)'(PREROLL_DEPTH))
                         : PRE_IW'(replay_base_raw);

    always_comb
    begin
        amplitude_sum_next = amplitude_sum_reg;
        is_recording_next = is_recording_reg;
        is_sleeping_next = is_sleeping_reg;
        voice_streak_next = voice_streak_reg;
        last_voice_time_next = last_voice_time_reg;
        force_deadline_next = force_deadline_reg;
        preroll_write_index_next = preroll_write_index_reg;
        preroll_count_next = preroll_count_reg;
        replay_index_next = replay_index_reg;
        replay_pending_next = replay_pending_reg;
        backlog_read_index_next = backlog_read_index_reg;
        backlog_write_index_next = backlog_write_index_reg;
        backlog_count_next = backlog_count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next = out_data_reg;
        force_active = 1'b0;
        voiced = 1'b0;
        silence_span = '0;
        action = ACT_FORWARD_LIVE;
        wslot_pre = '0;
        wslot_bkl = '0;
        rslot_pre = '0;
        rslot_bkl = '0;
        use_bkl_wslot = 1'b0;
        use_bkl_rslot = 1'b0;
        started = 1'b0;
        stopped = 1'b0;

        if (accept)
        begin
            if (!in_data.frame_last)
            begin
                amplitude_sum_next = acc_sat;
            end
            else
            begin
                amplitude_sum_next = '0;

                if (in_data.force_press)
                begin
                    force_deadline_next = deadline_sum[32] ? 32'hFFFF_FFFF : deadline_sum[31:0];
                end
                force_active = in_data.now_ms < force_deadline_next;

                if (in_data.wake_event || in_data.force_press)
                begin
                    voice_streak_next = '0;
                    last_voice_time_next = in_data.now_ms;
                    if (!force_active)
                    begin
                        is_recording_next = 1'b0;
                    end
                end

                voiced = (voice_threshold_reg == ALWAYS_VOICE)
                         || ({{(CMP_W-SUM_W){1'b0}}, acc_sat} >= threshold_target)
                         || force_active;

                if (voiced)
                begin
                    last_voice_time_next = in_data.now_ms;
                    if (!is_recording_next)
                    begin
                        if (voice_streak_next != 8'hFF)
                        begin
                            voice_streak_next = voice_streak_next + 8'd1;
                        end
                        if (voice_streak_next >= debounce_frames_reg)
                        begin
                            if (preroll_count_reg != '0)
                            begin
                                replay_index_next = replay_base;
                                replay_pending_next = replay_n;
                                preroll_write_index_next = '0;
                                preroll_count_next = '0;
                            end
                            is_recording_next = 1'b1;
                            is_sleeping_next = 1'b0;
                            started = 1'b1;
                        end
                    end
                end
                else
                begin
                    voice_streak_next = '0;
                    if (is_recording_next)
                    begin
                        silence_span = (in_data.now_ms >= last_voice_time_next)
                                       ? in_data.now_ms - last_voice_time_next : '0;
                        if (silence_span >= silence_hold_ms_reg)
                        begin
                            is_recording_next = 1'b0;
                            is_sleeping_next = 1'b1;
                            stopped = 1'b1;
                            preroll_write_index_next = '0;
                            preroll_count_next = '0;
                            replay_index_next = '0;
                            replay_pending_next = '0;
                            backlog_read_index_next = '0;
                            backlog_write_index_next = '0;
                            backlog_count_next = '0;
                        end
                    end
                end

                priority if (!is_recording_next)
                begin
                    action = ACT_STORE_PREROLL;
                    wslot_pre = preroll_write_index_next;
                    preroll_write_index_next =
                        (preroll_write_index_next == PRE_IW'(PREROLL_DEPTH - 1))
                        ? '0 : preroll_write_index_next + PRE_IW'(1);
                    if (preroll_count_next < CNT_W'(PREROLL_DEPTH))
                    begin
                        preroll_count_next = preroll_count_next + CNT_W'(1);
                    end
                end
                else if (replay_pending_next != '0)
                begin
                    if (backlog_count_next >= CNT_W'(BACKLOG_DEPTH))
                    begin
                        action = ACT_DROP_LIVE;
                    end
                    else
                    begin
                        action = ACT_REPLAY_PREROLL;
                        use_bkl_wslot = 1'b1;
                        wslot_bkl = backlog_write_index_next;
                        backlog_write_index_next =
                            (backlog_write_index_next == BKL_IW'(BACKLOG_DEPTH - 1))
                            ? '0 : backlog_write_index_next + BKL_IW'(1);
                        backlog_count_next = backlog_count_next + CNT_W'(1);
                        rslot_pre = replay_index_next;
                        replay_index_next = (replay_index_next == PRE_IW'(PREROLL_DEPTH - 1))
                                            ? '0 : replay_index_next + PRE_IW'(1);
                        replay_pending_next = replay_pending_next - CNT_W'(1);
                    end
                end
                else if (backlog_count_next != '0)
                begin
                    action = ACT_FLUSH_BACKLOG;
                    use_bkl_rslot = 1'b1;
                    use_bkl_wslot = 1'b1;
                    rslot_bkl = backlog_read_index_next;
                    backlog_read_index_next =
                        (backlog_read_index_next == BKL_IW'(BACKLOG_DEPTH - 1))
                        ? '0 : backlog_read_index_next + BKL_IW'(1);
                    wslot_bkl = backlog_write_index_next;
                    backlog_write_index_next =
                        (backlog_write_index_next == BKL_IW'(BACKLOG_DEPTH - 1))
                        ? '0 : backlog_write_index_next + BKL_IW'(1);
                end
                else
                begin
                    action = ACT_FORWARD_LIVE;
                end

                out_valid_next = 1'b1;
                out_data_next.frame_action = action;
                out_data_next.write_slot = use_bkl_wslot ? wslot_bkl[2:0] : wslot_pre[2:0];
                out_data_next.read_slot = use_bkl_rslot ? rslot_bkl[2:0] : rslot_pre[2:0];
                out_data_next.recording = is_recording_next;
                out_data_next.sleeping = is_sleeping_next;
                out_data_next.started = started;
                out_data_next.stopped = stopped;
                out_data_next.voiced = voiced;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_threshold_reg <= RST_VOICE_THRESHOLD;
            debounce_frames_reg <= RST_DEBOUNCE_FRAMES;
            silence_hold_ms_reg <= RST_SILENCE_HOLD_MS;
            force_hold_ms_reg <= RST_FORCE_HOLD_MS;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_VOICE_THRESHOLD: voice_threshold_reg <= cfg_data[15:0];
                REG_DEBOUNCE_FRAMES: debounce_frames_reg <= cfg_data[7:0];
                REG_SILENCE_HOLD_MS: silence_hold_ms_reg <= cfg_data;
                REG_FORCE_HOLD_MS: force_hold_ms_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_sum_reg <= '0;
            is_recording_reg <= 1'b0;
            is_sleeping_reg <= 1'b0;
            voice_streak_reg <= '0;
            last_voice_time_reg <= '0;
            force_deadline_reg <= '0;
            preroll_write_index_reg <= '0;
            preroll_count_reg <= '0;
            replay_index_reg <= '0;
            replay_pending_reg <= '0;
            backlog_read_index_reg <= '0;
            backlog_write_index_reg <= '0;
            backlog_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            amplitude_sum_reg <= amplitude_sum_next;
            is_recording_reg <= is_recording_next;
            is_sleeping_reg <= is_sleeping_next;
            voice_streak_reg <= voice_streak_next;
            last_voice_time_reg <= last_voice_time_next;
            force_deadline_reg <= force_deadline_next;
            preroll_write_index_reg <= preroll_write_index_next;
            preroll_count_reg <= preroll_count_next;
            replay_index_reg <= replay_index_next;
            replay_pending_reg <= replay_pending_next;
            backlog_read_index_reg <= backlog_read_index_next;
            backlog_write_index_reg <= backlog_write_index_next;
            backlog_count_reg <= backlog_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    a_frame_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.frame_last) |=> out_valid)
        else $error("A frame end request did not load a result.");

    a_counts_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (preroll_count_reg <= CNT_W'(PREROLL_DEPTH))
        && (backlog_count_reg <= CNT_W'(BACKLOG_DEPTH)))
        else $error("A ring count is beyond its depth.");

    a_start_means_recording: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.started) |-> (out_data.recording && !out_data.sleeping))
        else $error("A started frame is not recording.");

    a_stop_means_sleeping: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.stopped)
        |-> (!out_data.recording && out_data.sleeping && !out_data.voiced))
        else $error("A stopped frame is not sleeping.");

    a_idle_stores_preroll: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.recording) |-> (out_data.frame_action == ACT_STORE_PREROLL))
        else $error("A frame outside recording was not stored in the pre-roll ring.");

endmodule
